// ===== rtl/distance_bar_graph_colour_mapper_macros.svh =====
// Assertion macros for the distance bar graph colour mapper checker
`ifndef DISTANCE_BAR_GRAPH_COLOUR_MAPPER_MACROS_SVH
`define DISTANCE_BAR_GRAPH_COLOUR_MAPPER_MACROS_SVH

// Checked only while out of reset
`define DBGCM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked on every edge, reset included
`define DBGCM_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/dbgcm_pkg.sv =====
// Types and constants shared by the distance bar graph colour mapper
`timescale 1ns / 1ps
`default_nettype none

package dbgcm_pkg;

    localparam int unsigned NumLeds     = 16;
    localparam int unsigned LedIdxW     = 4;
    localparam int unsigned DistW       = 16;
    localparam int unsigned LightW      = 12;
    localparam int unsigned LvlW        = 8;
    localparam int unsigned CountW      = 5;     // lit count 0..16
    localparam int unsigned FracW       = 2;     // 1..3 thirds
    localparam int unsigned FacW        = 11;    // brightness factor 96..1119
    localparam int unsigned ProdW       = LvlW + FacW;
    localparam int unsigned QuotW       = 9;
    localparam int unsigned RecipW      = ProdW + 11;

    localparam int unsigned FarLimit    = 50;
    localparam int unsigned NearLimit   = 5;
    localparam int unsigned AllLit      = 16;
    localparam int unsigned LevelStep   = 17;    // k*10000/588 == k*17 for k <= 15
    localparam int unsigned LightOffset = 19;
    localparam int unsigned FactorBase  = 100;
    localparam int unsigned ScaleDiv    = 1000;
    localparam int unsigned LevelMax    = 255;

    // x/1000 ~ (x*1048)>>20, low by at most one over the product range
    localparam int unsigned Div1000Mul  = 1048;
    localparam int unsigned Div1000Sh   = 20;
    // x/3 == (x*683)>>11 exactly for x < 2048
    localparam int unsigned Div3Mul     = 683;
    localparam int unsigned Div3Sh      = 11;
    // x/3 == (x*171)>>9 exactly for 6 bit x
    localparam int unsigned Div3SmMul   = 171;
    localparam int unsigned Div3SmSh    = 9;

    typedef struct packed {
        logic [DistW-1:0]  distance_cm;
        logic [LightW-1:0] light_sample;
    } t_dist_in;

    typedef struct packed {
        logic [LedIdxW-1:0] led_index;
        logic [LvlW-1:0]    green_level;
        logic [LvlW-1:0]    red_level;
        logic [LvlW-1:0]    blue_level;
        logic               last_led;
    } t_led_res;

    // per item parameters out of the front end
    typedef struct packed {
        logic [CountW-1:0] lit;
        logic [LvlW-1:0]   green;
        logic [LvlW-1:0]   red;
        logic [FracW-1:0]  frac;
        logic [FacW-1:0]   factor;
    } t_item_par;

    // one LED before brightness scaling
    typedef struct packed {
        logic [LedIdxW-1:0] idx;
        logic               last;
        logic [LvlW-1:0]    green;
        logic [LvlW-1:0]    red;
        logic [FacW-1:0]    factor;
    } t_led_raw;

endpackage

`default_nettype wire

// ===== rtl/dbgcm_prep.sv =====
// Front end: input register and per item lit count, base levels and brightness
`timescale 1ns / 1ps
`default_nettype none

module dbgcm_prep (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    input  wire dbgcm_pkg::t_dist_in  i_item,
    input  wire logic                 i_take,
    output logic                      busy,
    output logic                      o_par_valid,
    output dbgcm_pkg::t_item_par      o_par
);

    logic                   r_s0_v;
    dbgcm_pkg::t_dist_in    r_s0_item;
    logic                   r_s1_v;
    dbgcm_pkg::t_item_par   r_s1_par;

    logic                   s1_free;
    logic                   s0_free;
    logic                   load;

    logic [dbgcm_pkg::DistW-1:0]  distance;
    logic                         near;
    logic                         lit_range;
    logic [5:0]                   d6;
    logic [5:0]                   span;
    logic [13:0]                  span_m;
    logic [13:0]                  d6_m;
    logic [4:0]                   d6_q;
    logic [1:0]                   d6_mod;
    logic [dbgcm_pkg::CountW-1:0] lit;
    logic [3:0]                   gk;
    logic [3:0]                   rk;
    logic [dbgcm_pkg::LightW-1:0] adc;
    logic [dbgcm_pkg::LightW-1:0] adc_off;
    logic [dbgcm_pkg::FacW-1:0]   factor;
    dbgcm_pkg::t_item_par         n_s1_par;

    assign s1_free = !r_s1_v || i_take;
    assign s0_free = !r_s0_v || s1_free;
    assign busy    = !s0_free;
    assign load    = start && s0_free;

    always_comb begin
        distance  = r_s0_item.distance_cm;
        near      = distance < dbgcm_pkg::DistW'(dbgcm_pkg::NearLimit);
        lit_range = !near && (distance <= dbgcm_pkg::DistW'(dbgcm_pkg::FarLimit));
        d6        = distance[5:0];
        span      = 6'(dbgcm_pkg::FarLimit) - d6;
        span_m    = 14'(span) * 14'(dbgcm_pkg::Div3SmMul);
        d6_m      = 14'(d6) * 14'(dbgcm_pkg::Div3SmMul);
        d6_q      = 5'(d6_m >> dbgcm_pkg::Div3SmSh);
        // remainder only matters when the distance is at most 50
        d6_mod    = 2'(d6 - 6'(3) * 6'(d6_q));

        if (lit_range) begin
            lit = dbgcm_pkg::CountW'(span_m >> dbgcm_pkg::Div3SmSh) + 5'd1;
        end else if (near) begin
            lit = dbgcm_pkg::CountW'(dbgcm_pkg::AllLit);
        end else begin
            lit = '0;
        end

        gk = 4'(5'(dbgcm_pkg::AllLit) - lit);
        rk = 4'(lit - 5'd1);

        adc = r_s0_item.light_sample;
        // truncation toward zero on the dim side
        if (adc >= dbgcm_pkg::LightW'(dbgcm_pkg::LightOffset)) begin
            adc_off = adc - dbgcm_pkg::LightW'(dbgcm_pkg::LightOffset);
            factor  = dbgcm_pkg::FacW'(dbgcm_pkg::FactorBase)
                      + dbgcm_pkg::FacW'(adc_off >> 2);
        end else begin
            adc_off = dbgcm_pkg::LightW'(dbgcm_pkg::LightOffset) - adc;
            factor  = dbgcm_pkg::FacW'(dbgcm_pkg::FactorBase)
                      - dbgcm_pkg::FacW'(adc_off >> 2);
        end

        n_s1_par.lit    = lit;
        n_s1_par.green  = (lit == '0) ? '0
                          : dbgcm_pkg::LvlW'(8'(gk) * 8'(dbgcm_pkg::LevelStep));
        n_s1_par.red    = (lit == '0) ? '0
                          : dbgcm_pkg::LvlW'(8'(rk) * 8'(dbgcm_pkg::LevelStep));
        n_s1_par.frac   = 2'd3 - d6_mod;
        n_s1_par.factor = factor;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
            r_s1_v <= 1'b0;
        end else begin
            if (s0_free) begin
                r_s0_v <= load;
            end
            if (s1_free) begin
                r_s1_v <= r_s0_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_s0_item <= i_item;
        end
        if (s1_free) begin
            r_s1_par <= n_s1_par;
        end
    end

    assign o_par_valid = r_s1_v;
    assign o_par       = r_s1_par;

endmodule

`default_nettype wire

// ===== rtl/dbgcm_seq.sv =====
// LED sequencer: walks the strip one LED per cycle and picks the raw levels
`timescale 1ns / 1ps
`default_nettype none

module dbgcm_seq (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_par_valid,
    input  wire dbgcm_pkg::t_item_par  i_par,
    output logic                       o_take,
    output logic                       o_raw_valid,
    output dbgcm_pkg::t_led_raw        o_raw
);

    localparam logic [dbgcm_pkg::LedIdxW-1:0] LastIdx =
        dbgcm_pkg::LedIdxW'(dbgcm_pkg::NumLeds - 1);

    logic                               r_act;
    logic [dbgcm_pkg::LedIdxW-1:0]      r_cnt;
    logic [dbgcm_pkg::CountW-1:0]       r_lit;
    logic [dbgcm_pkg::LvlW-1:0]         r_g;
    logic [dbgcm_pkg::LvlW-1:0]         r_r;
    logic [dbgcm_pkg::LvlW-1:0]         r_gl;
    logic [dbgcm_pkg::LvlW-1:0]         r_rl;
    logic [dbgcm_pkg::FacW-1:0]         r_f;
    logic                               r_raw_v;
    dbgcm_pkg::t_led_raw                r_raw;

    logic [9:0]                         g_x;
    logic [9:0]                         r_x;
    logic [20:0]                        g_m;
    logic [20:0]                        r_m;
    logic [dbgcm_pkg::LvlW-1:0]         g_last;
    logic [dbgcm_pkg::LvlW-1:0]         r_last;
    logic [dbgcm_pkg::CountW-1:0]       pos;
    dbgcm_pkg::t_led_raw                n_raw;

    assign o_take = i_par_valid && (!r_act || (r_cnt == LastIdx));

    // last lit LED: level * frac / 3, frac in 1..3
    always_comb begin
        g_x = (i_par.frac == 2'd2) ? {1'b0, i_par.green, 1'b0} : {2'b00, i_par.green};
        r_x = (i_par.frac == 2'd2) ? {1'b0, i_par.red, 1'b0} : {2'b00, i_par.red};
        g_m = 21'(g_x) * 21'(dbgcm_pkg::Div3Mul);
        r_m = 21'(r_x) * 21'(dbgcm_pkg::Div3Mul);
        g_last = (i_par.frac == 2'd3) ? i_par.green
                 : dbgcm_pkg::LvlW'(g_m >> dbgcm_pkg::Div3Sh);
        r_last = (i_par.frac == 2'd3) ? i_par.red
                 : dbgcm_pkg::LvlW'(r_m >> dbgcm_pkg::Div3Sh);
    end

    always_comb begin
        pos          = dbgcm_pkg::CountW'(r_cnt) + 5'd1;
        n_raw.idx    = r_cnt;
        n_raw.last   = (r_cnt == LastIdx);
        n_raw.factor = r_f;
        if (pos < r_lit) begin
            n_raw.green = r_g;
            n_raw.red   = r_r;
        end else if (pos == r_lit) begin
            n_raw.green = r_gl;
            n_raw.red   = r_rl;
        end else begin
            n_raw.green = '0;
            n_raw.red   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act   <= 1'b0;
            r_cnt   <= '0;
            r_raw_v <= 1'b0;
        end else begin
            r_raw_v <= r_act;
            if (o_take) begin
                r_act <= 1'b1;
                r_cnt <= '0;
            end else if (r_act) begin
                if (r_cnt == LastIdx) begin
                    r_act <= 1'b0;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_lit <= i_par.lit;
            r_g   <= i_par.green;
            r_r   <= i_par.red;
            r_gl  <= g_last;
            r_rl  <= r_last;
            r_f   <= i_par.factor;
        end
        r_raw <= n_raw;
    end

    assign o_raw_valid = r_raw_v;
    assign o_raw       = r_raw;

endmodule

`default_nettype wire

// ===== rtl/dbgcm_scale.sv =====
// Brightness scaling pipeline: c*f/1000, keep c when the result exceeds 255
`timescale 1ns / 1ps
`default_nettype none

module dbgcm_scale (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire dbgcm_pkg::t_led_raw  i_raw,
    output logic                      o_valid,
    output dbgcm_pkg::t_led_res       o_res
);

    localparam int unsigned PW = dbgcm_pkg::ProdW;
    localparam int unsigned TW = dbgcm_pkg::RecipW;
    localparam int unsigned QW = dbgcm_pkg::QuotW;
    localparam int unsigned LW = dbgcm_pkg::LvlW;

    // channel 0 green, channel 1 red
    logic                           r1_v;
    logic [dbgcm_pkg::LedIdxW-1:0]  r1_idx;
    logic                           r1_last;
    logic [LW-1:0]                  r1_c [2];
    logic [PW-1:0]                  r1_p [2];

    logic                           r2_v;
    logic [dbgcm_pkg::LedIdxW-1:0]  r2_idx;
    logic                           r2_last;
    logic [LW-1:0]                  r2_c [2];
    logic [PW-1:0]                  r2_p [2];
    logic [QW-1:0]                  r2_q [2];

    logic                           r3_v;
    dbgcm_pkg::t_led_res            r3_res;

    logic [TW-1:0]                  recip [2];
    logic [PW-1:0]                  rem   [2];
    logic [QW-1:0]                  quot  [2];
    logic [LW-1:0]                  lvl   [2];

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            recip[k] = TW'(r1_p[k]) * TW'(dbgcm_pkg::Div1000Mul);
            // estimate is at most one low
            rem[k]   = r2_p[k] - PW'(r2_q[k]) * PW'(dbgcm_pkg::ScaleDiv);
            quot[k]  = (rem[k] >= PW'(dbgcm_pkg::ScaleDiv)) ? r2_q[k] + 1'b1 : r2_q[k];
            lvl[k]   = (quot[k] <= QW'(dbgcm_pkg::LevelMax)) ? LW'(quot[k]) : r2_c[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_idx  <= i_raw.idx;
        r1_last <= i_raw.last;
        r1_c[0] <= i_raw.green;
        r1_c[1] <= i_raw.red;
        r1_p[0] <= PW'(i_raw.green) * PW'(i_raw.factor);
        r1_p[1] <= PW'(i_raw.red) * PW'(i_raw.factor);

        r2_idx  <= r1_idx;
        r2_last <= r1_last;
        for (int k = 0; k < 2; k++) begin
            r2_c[k] <= r1_c[k];
            r2_p[k] <= r1_p[k];
            r2_q[k] <= QW'(recip[k] >> dbgcm_pkg::Div1000Sh);
        end

        r3_res.led_index   <= r2_idx;
        r3_res.green_level <= lvl[0];
        r3_res.red_level   <= lvl[1];
        r3_res.blue_level  <= '0;
        r3_res.last_led    <= r2_last;
    end

    assign o_valid = r3_v;
    assign o_res   = r3_res;

endmodule

`default_nettype wire

// ===== rtl/distance_bar_graph_colour_mapper.sv =====
// Top level of the distance bar graph colour mapper
//
//  Port group        Dir  Handshake                      Content
//  start / i_item    in   transfer when start && !busy   distance and light sample
//  o_strobe/o_result out  one cycle per strobe, no stall one LED: index, G, R, B, last
//
// Each input item yields 16 results, one per cycle, LED 0 first, at the rate
// set by the LED sequencer that walks the strip. An item's LED 0 passes the
// input and parameter registers, the sequencer and the scaler to the outputs.
// Two items can wait in front of the sequencer; busy rises only when both
// are taken. Results never stall and run back to back when the next item waits.
// Synchronous active-low reset clears all valid state; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module distance_bar_graph_colour_mapper (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    input  wire dbgcm_pkg::t_dist_in  i_item,
    output logic                      busy,
    output logic                      o_strobe,
    output dbgcm_pkg::t_led_res       o_result
);

    logic                   par_valid;
    dbgcm_pkg::t_item_par   par;
    logic                   take;
    logic                   raw_valid;
    dbgcm_pkg::t_led_raw    raw;

    dbgcm_prep u_prep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_item      (i_item),
        .i_take      (take),
        .busy        (busy),
        .o_par_valid (par_valid),
        .o_par       (par)
    );

    dbgcm_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_par_valid (par_valid),
        .i_par       (par),
        .o_take      (take),
        .o_raw_valid (raw_valid),
        .o_raw       (raw)
    );

    dbgcm_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (raw_valid),
        .i_raw   (raw),
        .o_valid (o_strobe),
        .o_res   (o_result)
    );

endmodule

`default_nettype wire

// ===== rtl/dbgcm_checker.sv =====
// Port level checker for the distance bar graph colour mapper, with its bind
`timescale 1ns / 1ps
`default_nettype none
`include "distance_bar_graph_colour_mapper_macros.svh"

module dbgcm_checker (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 busy,
    input  wire logic                 o_strobe,
    input  wire dbgcm_pkg::t_led_res  o_result
);

    // within one item the LEDs follow each other with no gap
    `DBGCM_ASSERT(a_led_run, o_strobe && !o_result.last_led |=> o_strobe && (o_result.led_index == $past(o_result.led_index) + 4'd1), "LED sequence broken")

    `DBGCM_ASSERT(a_last_flag, o_strobe |-> (o_result.last_led == (o_result.led_index == 4'd15)), "last_led flag does not match index")

    `DBGCM_ASSERT(a_blue_dark, o_strobe |-> (o_result.blue_level == 8'd0), "blue level not zero")

    `DBGCM_ASSERT_RST(a_rst_quiet, !i_rst_n |=> !o_strobe && !busy, "activity right after reset")

endmodule

bind distance_bar_graph_colour_mapper dbgcm_checker u_dbgcm_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

`default_nettype wire
